FILE: src/itacc_pkg.sv
// ----------------------------------------------------------------------------
// itacc_pkg
// Shared types, constants and the control program of the interval time
// accumulator.
// ----------------------------------------------------------------------------
package itacc_pkg;

  // Width of the elapsed cycle count
  localparam int ELAPSED_BITS = 32;
  localparam int CNT_W        = $clog2(ELAPSED_BITS);
  localparam int REG_W        = 32;
  localparam int TOTAL_W      = 64;
  localparam int CFG_IDX_W    = 1;

  // Reset values of the configuration registers
  localparam logic [REG_W-1:0] CYCLES_PER_UNIT_RST = REG_W'(4);
  localparam logic [REG_W-1:0] TIME_PER_UNIT_RST   = REG_W'(3000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_UNIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_PER_UNIT   = CFG_IDX_W'(1);

  // Program counter
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // Program step addresses
  localparam pc_t PC_LOAD   = PC_W'(0);
  localparam pc_t PC_BYPASS = PC_W'(1);
  localparam pc_t PC_DIV    = PC_W'(2);
  localparam pc_t PC_DIFF   = PC_W'(3);
  localparam pc_t PC_ACC    = PC_W'(4);
  localparam pc_t PC_EMIT   = PC_W'(5);
  localparam pc_t PC_RET    = PC_W'(6);

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_BYPASS,
    OP_DIV,
    OP_DIFF,
    OP_ACC,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_ZERO_DIV,
    JC_MORE_BITS,
    JC_OUT_BUSY
  } cond_e;

  // One control word of the program
  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic zero_div;
    logic more_bits;
    logic out_busy;
  } status_t;

  // Control program, one word per step
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,   cond: JC_NO_INPUT,  target: PC_LOAD};
      PC_BYPASS: w = '{op: OP_BYPASS, cond: JC_ZERO_DIV,  target: PC_ACC};
      PC_DIV:    w = '{op: OP_DIV,    cond: JC_MORE_BITS, target: PC_DIV};
      PC_DIFF:   w = '{op: OP_DIFF,   cond: JC_NEVER,     target: PC_LOAD};
      PC_ACC:    w = '{op: OP_ACC,    cond: JC_NEVER,     target: PC_LOAD};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: JC_OUT_BUSY,  target: PC_EMIT};
      PC_RET:    w = '{op: OP_NONE,   cond: JC_ALWAYS,    target: PC_LOAD};
      default:   w = '{op: OP_NONE,   cond: JC_ALWAYS,    target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: src/itacc_seq.sv
// ----------------------------------------------------------------------------
// itacc_seq
// Step counter and program table; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module itacc_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itacc_pkg::status_t status_i,
  output itacc_pkg::ctrl_t   ctrl_o
);
  import itacc_pkg::*;

  pc_t   pc_q, pc_d;
  ctrl_t word;
  logic  take_jump;

  // Fetch the current control word
  assign word   = ucode(pc_q);
  assign ctrl_o = word;

  // Evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      JC_NEVER:     take_jump = 1'b0;
      JC_ALWAYS:    take_jump = 1'b1;
      JC_NO_INPUT:  take_jump = !status_i.in_valid;
      JC_ZERO_DIV:  take_jump = status_i.zero_div;
      JC_MORE_BITS: take_jump = status_i.more_bits;
      JC_OUT_BUSY:  take_jump = status_i.out_busy;
      default:      take_jump = 1'b1;
    endcase
    pc_d = take_jump ? word.target : pc_q + PC_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  // A transfer in always starts the program body
  a_load_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_LOAD && status_i.in_valid) |=> pc_q == PC_BYPASS)
    else $error("accepted item did not start the program");

  // The last quotient bit hands over to the difference step
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.op == OP_DIV && !status_i.more_bits) |=> pc_q == PC_DIFF)
    else $error("division loop did not end at the difference step");

  // The unused program slot is never reached
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q != PC_W'(7))
    else $error("step counter left the program");

endmodule

FILE: src/itacc_dp.sv
// ----------------------------------------------------------------------------
// itacc_dp
// Datapath: configuration registers, shift-subtract divider, scaled time
// accumulator, running totals and the output register.
// ----------------------------------------------------------------------------
module itacc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itacc_pkg::ctrl_t                  ctrl_i,
  output itacc_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  logic [itacc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [itacc_pkg::REG_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic [itacc_pkg::ELAPSED_BITS-1:0] elapsed_cycles_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [itacc_pkg::REG_W-1:0]       leftover_cycles_o,
  output logic [itacc_pkg::TOTAL_W-1:0]     cycle_stamp_o,
  output logic [itacc_pkg::TOTAL_W-1:0]     raw_time_o
);
  import itacc_pkg::*;

  logic [REG_W-1:0]        cpu_q, tpu_q;
  logic [ELAPSED_BITS-1:0] count_q, count_d;
  logic [REG_W-1:0]        rem_q, rem_d;
  logic [ELAPSED_BITS-1:0] diff_q, diff_d;
  logic [TOTAL_W-1:0]      tacc_q, tacc_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [TOTAL_W-1:0]      ctot_q, ctot_d, ttot_q, ttot_d;
  logic                    out_valid_q, out_valid_d;
  logic [REG_W-1:0]        left_out_q, left_out_d;
  logic [TOTAL_W-1:0]      cstamp_q, cstamp_d, rtime_q, rtime_d;
  logic [REG_W:0]          trial;
  logic                    fits;
  logic                    zero_div;
  logic                    out_free;

  assign zero_div = (cpu_q == '0);
  assign out_free = !out_valid_q || out_ready_i;

  // One restoring step: bring down the next count bit and try the interval
  assign trial = {rem_q, count_q[cnt_q]};
  assign fits  = (trial >= {1'b0, cpu_q});

  // Status to the sequencer
  assign status_o = '{in_valid:  in_valid_i,
                      zero_div:  zero_div,
                      more_bits: (cnt_q != '0),
                      out_busy:  !out_free};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= CYCLES_PER_UNIT_RST;
      tpu_q <= TIME_PER_UNIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CYCLES_PER_UNIT: cpu_q <= cfg_wdata_i;
        REG_TIME_PER_UNIT:   tpu_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Datapath operations
  always_comb begin
    count_d     = count_q;
    rem_d       = rem_q;
    diff_d      = diff_q;
    tacc_d      = tacc_q;
    cnt_d       = cnt_q;
    ctot_d      = ctot_q;
    ttot_d      = ttot_q;
    out_valid_d = out_valid_q;
    left_out_d  = left_out_q;
    cstamp_d    = cstamp_q;
    rtime_d     = rtime_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (ctrl_i.op)
      OP_NONE: ;
      OP_LOAD: begin
        if (in_valid_i) begin
          count_d = elapsed_cycles_i;
          rem_d   = '0;
          diff_d  = '0;
          tacc_d  = '0;
          cnt_d   = CNT_W'(ELAPSED_BITS - 1);
        end
      end
      OP_BYPASS: begin
        // Zero interval: keep the count as leftover, accumulate nothing
        if (zero_div) begin
          rem_d  = REG_W'(count_q);
          diff_d = '0;
        end
      end
      OP_DIV: begin
        rem_d  = fits ? REG_W'(trial - {1'b0, cpu_q}) : REG_W'(trial);
        tacc_d = (tacc_q << 1) + (fits ? TOTAL_W'(tpu_q) : '0);
        cnt_d  = cnt_q - CNT_W'(1);
      end
      OP_DIFF: begin
        diff_d = count_q - ELAPSED_BITS'(rem_q);
      end
      OP_ACC: begin
        ctot_d = ctot_q + TOTAL_W'(diff_q);
        ttot_d = ttot_q + tacc_q;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          left_out_d  = rem_q;
          cstamp_d    = ctot_q;
          rtime_d     = ttot_q;
        end
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctot_q      <= '0;
      ttot_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      ctot_q      <= ctot_d;
      ttot_q      <= ttot_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    rem_q      <= rem_d;
    diff_q     <= diff_d;
    tacc_q     <= tacc_d;
    left_out_q <= left_out_d;
    cstamp_q   <= cstamp_d;
    rtime_q    <= rtime_d;
  end

  assign out_valid_o       = out_valid_q;
  assign leftover_cycles_o = left_out_q;
  assign cycle_stamp_o     = cstamp_q;
  assign raw_time_o        = rtime_q;

  // Remainder after the division is below the interval
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DIFF && !zero_div) |-> rem_q < cpu_q)
    else $error("remainder not below the interval");

  // Whole-unit cycles plus leftover give back the count
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_ACC && !zero_div) |-> diff_q + ELAPSED_BITS'(rem_q) == count_q)
    else $error("cycle split does not sum to the count");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(cstamp_q) && $stable(rtime_q))
    else $error("pending result overwritten");

endmodule

FILE: src/interval_time_accumulator.sv
// ----------------------------------------------------------------------------
// interval_time_accumulator
// Splits an elapsed cycle count into whole intervals and a leftover and
// accumulates the cycle stamp and the scaled raw time.
// ----------------------------------------------------------------------------
// Sequence: an accepted item runs the bypass step, the division loop and the
//   difference, accumulate and emit steps; bypass skips to accumulate when
//   cycles_per_unit is zero. One quotient bit per cycle, from the single
//   shift-subtract step. A new item is taken only in the load step, after the
//   last one is emitted; emit waits while the previous result is not taken.
// Reset: totals clear to zero, cycles_per_unit to 4, time_per_unit to 3000.
module interval_time_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [itacc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [itacc_pkg::REG_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [itacc_pkg::ELAPSED_BITS-1:0] elapsed_cycles_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [itacc_pkg::REG_W-1:0]        leftover_cycles_o,
  output logic [itacc_pkg::TOTAL_W-1:0]      cycle_stamp_o,
  output logic [itacc_pkg::TOTAL_W-1:0]      raw_time_o
);
  import itacc_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Accept an item only in the load step
  assign in_ready_o = (ctrl.op == OP_LOAD);

  itacc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  itacc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .elapsed_cycles_i  (elapsed_cycles_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .leftover_cycles_o (leftover_cycles_o),
    .cycle_stamp_o     (cycle_stamp_o),
    .raw_time_o        (raw_time_o)
  );

endmodule

FILE: tb/tb_interval_time_accumulator.sv
// ----------------------------------------------------------------------------
// tb_interval_time_accumulator
// Self-checking bench for the interval time accumulator. A scoreboard keeps
// its own copy of the interval settings and of both running totals and
// predicts leftover, cycle stamp and raw time for every input transfer.
// Directed corner cases come first. Random settings and counts follow, with
// random gaps on both channels, one long receiver hold-off and one phase
// with no gaps at all.
// ----------------------------------------------------------------------------
module tb_interval_time_accumulator;
  import itacc_pkg::*;

  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 102;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 6;
  localparam int END_CYCLES    = 60;
  localparam int IDLE_LIMIT    = 5000;

  // One predicted result
  typedef struct packed {
    logic [REG_W-1:0]   leftover;
    logic [TOTAL_W-1:0] stamp;
    logic [TOTAL_W-1:0] raw_time;
  } accum_result_t;

  // Predicts the totals and holds the results still to come
  class accum_scoreboard;
    logic [REG_W-1:0]   unit_cycles;
    logic [REG_W-1:0]   unit_time;
    logic [TOTAL_W-1:0] cycle_total;
    logic [TOTAL_W-1:0] time_total;
    accum_result_t      pending_q[$];
    int errors;
    int checked;
    int zero_unit_items;
    int short_items;
    int time_wraps;

    function new();
      unit_cycles     = CYCLES_PER_UNIT_RST;
      unit_time       = TIME_PER_UNIT_RST;
      cycle_total     = '0;
      time_total      = '0;
      errors          = 0;
      checked         = 0;
      zero_unit_items = 0;
      short_items     = 0;
      time_wraps      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      case (idx)
        REG_CYCLES_PER_UNIT: unit_cycles = value;
        REG_TIME_PER_UNIT:   unit_time   = value;
        default: ;
      endcase
    endfunction

    // Take whole intervals out of the count and advance both totals
    function void note_input(logic [ELAPSED_BITS-1:0] count);
      accum_result_t      res;
      logic [TOTAL_W-1:0] quot;
      logic [TOTAL_W-1:0] prev_time;
      res.leftover = REG_W'(count);
      if (unit_cycles == '0) begin
        zero_unit_items++;
      end else if (TOTAL_W'(count) < TOTAL_W'(unit_cycles)) begin
        short_items++;
      end else begin
        quot         = TOTAL_W'(count) / TOTAL_W'(unit_cycles);
        res.leftover = REG_W'(TOTAL_W'(count) % TOTAL_W'(unit_cycles));
        prev_time    = time_total;
        cycle_total  = cycle_total + quot * TOTAL_W'(unit_cycles);
        time_total   = time_total + quot * TOTAL_W'(unit_time);
        if (time_total < prev_time) time_wraps++;
      end
      res.stamp    = cycle_total;
      res.raw_time = time_total;
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [REG_W-1:0] leftover, logic [TOTAL_W-1:0] stamp,
                               logic [TOTAL_W-1:0] rtime);
      accum_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: leftover_cycles=%0d cycle_stamp=%0d raw_time=%0d",
               leftover, stamp, rtime);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (leftover !== want.leftover) begin
        $error("leftover_cycles: expected %0d, got %0d", want.leftover, leftover);
        errors++;
      end
      if (stamp !== want.stamp) begin
        $error("cycle_stamp: expected %0d, got %0d", want.stamp, stamp);
        errors++;
      end
      if (rtime !== want.raw_time) begin
        $error("raw_time: expected %0d, got %0d", want.raw_time, rtime);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i        = REG_CYCLES_PER_UNIT;
  logic [REG_W-1:0]        cfg_wdata_i      = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic [ELAPSED_BITS-1:0] elapsed_cycles_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic [REG_W-1:0]        leftover_cycles_o;
  logic [TOTAL_W-1:0]      cycle_stamp_o;
  logic [TOTAL_W-1:0]      raw_time_o;

  accum_scoreboard sb = new();

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;
  int holds_done    = 0;
  int settings_used = 0;
  int idle_cycles   = 0;

  interval_time_accumulator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .elapsed_cycles_i  (elapsed_cycles_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .leftover_cycles_o (leftover_cycles_o),
    .cycle_stamp_o     (cycle_stamp_o),
    .raw_time_o        (raw_time_o)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset at the start, then release it once
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Track register writes and both transfers; end the run when nothing moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o) sb.note_input(elapsed_cycles_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(leftover_cycles_o, cycle_stamp_o, raw_time_o);
      end
      if (cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin : result_sink
    int span;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (rx_steady) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(99) < 60) begin
        span = $urandom_range(40, 1);
        out_ready_i <= 1'b1;
        repeat (span) @(posedge clk_i);
      end else begin
        span = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(150, 20);
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (tx_steady || r < 40) return 0;
    if (r < 75) return $urandom_range(5, 1);
    if (r < 95) return $urandom_range(50, 6);
    return $urandom_range(200, 51);
  endfunction

  function automatic logic [REG_W-1:0] pick_unit_cycles();
    int r;
    r = $urandom_range(9);
    case (r)
      0, 1, 2: return REG_W'($urandom_range(16, 1));
      3, 4:    return REG_W'($urandom_range(65535, 17));
      5, 6:    return REG_W'($urandom());
      7:       return '0;
      8:       return '1;
      default: return REG_W'(1) << $urandom_range(31);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_unit_time();
    int r;
    r = $urandom_range(9);
    if (r < 6) return REG_W'($urandom());
    if (r == 6) return '0;
    if (r == 7) return '1;
    return REG_W'($urandom_range(5000));
  endfunction

  // Mix of full-range counts and counts close to whole intervals
  function automatic logic [ELAPSED_BITS-1:0] pick_count(logic [REG_W-1:0] unit);
    int                 r;
    logic [TOTAL_W-1:0] near;
    r = $urandom_range(99);
    if (r < 40) return ELAPSED_BITS'($urandom());
    if (r < 60) return ELAPSED_BITS'($urandom_range(255));
    if (r < 80) begin
      near = TOTAL_W'(unit) * TOTAL_W'($urandom_range(8)) + TOTAL_W'($urandom_range(2));
      near = near - TOTAL_W'(1);
      return ELAPSED_BITS'(near);
    end
    if (r < 88) return ELAPSED_BITS'($urandom() >> $urandom_range(31));
    if (r < 94) return '1;
    return '0;
  endfunction

  // Offer one count and hold it until the transfer
  task automatic send_count(input logic [ELAPSED_BITS-1:0] count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    elapsed_cycles_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // give the sequencer time to return to its load step
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [REG_W-1:0] unit_cyc,
                               input logic [REG_W-1:0] unit_tim);
    write_reg(REG_CYCLES_PER_UNIT, unit_cyc);
    write_reg(REG_TIME_PER_UNIT, unit_tim);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [REG_W-1:0] unit_cyc;
    logic [REG_W-1:0] unit_tim;
    wait (rst_ni);
    @(posedge clk_i);

    // Reset setting: counts below, at and above one interval, full range
    send_count('0);
    send_count(ELAPSED_BITS'(3));
    send_count(ELAPSED_BITS'(4));
    send_count(ELAPSED_BITS'(5));
    send_count('1);
    send_count(ELAPSED_BITS'(32'h8000_0000));
    settle();

    // One-cycle interval, largest time step: raw time wraps
    apply_setting(REG_W'(1), '1);
    send_count('1);
    send_count('1);
    send_count('1);
    send_count(ELAPSED_BITS'(1));
    send_count('0);
    settle();

    // Zero interval: nothing accumulates, leftover is the count
    apply_setting('0, REG_W'(7));
    send_count('1);
    send_count('0);
    send_count(ELAPSED_BITS'(32'h1234_5678));
    settle();

    // Largest interval, zero time step
    apply_setting('1, '0);
    send_count('1);
    send_count(ELAPSED_BITS'(32'hFFFF_FFFE));
    send_count('0);
    settle();

    // Top-bit interval
    apply_setting(REG_W'(32'h8000_0000), REG_W'(1));
    send_count(ELAPSED_BITS'(32'h8000_0000));
    send_count(ELAPSED_BITS'(32'h7FFF_FFFF));
    send_count('1);
    settle();

    // Random settings and counts
    for (int p = 0; p < RAND_PHASES; p++) begin
      unit_cyc = pick_unit_cycles();
      unit_tim = pick_unit_time();
      apply_setting(unit_cyc, unit_tim);
      tx_steady = (p == 3) || (p == 7);
      rx_steady = (p == 7);
      if (p == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_count(pick_count(unit_cyc));
      settle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    repeat (END_CYCLES) @(posedge clk_i);
    $display("Covered %0d results over %0d interval settings, %0d receiver hold-offs.",
             sb.checked, settings_used + 1, holds_done);
    $display("Zero-interval counts: %0d, counts below one interval: %0d, raw time wraps: %0d.",
             sb.zero_unit_items, sb.short_items, sb.time_wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
